// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands for the SHA-256 pad/schedule block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define S256_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define S256_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/s256ps_pkg.sv -----
// ---------------------------------------------------------------------------
// s256ps_pkg
// Types, constants and sigma functions for the SHA-256 pad/schedule block.
// ---------------------------------------------------------------------------
package s256ps_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumCell = 16;   // schedule window, W[t-16..t-1]

  localparam logic [5:0] LAST_POS    = 6'd63;  // last byte slot of a block
  localparam logic [5:0] LEN_POS     = 6'd56;  // first slot of the length field
  localparam logic [4:0] LAST_PAIR   = 5'd31;
  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  typedef logic [WordW-1:0] word_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_EMIT
  } state_t;

  // What every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_BYTE,
    CM_PAIR
  } cell_mode_t;

  function automatic word_t rotr(input word_t v, input int unsigned s);
    rotr = (v >> s) | (v << (WordW - s));
  endfunction

  function automatic word_t small_s0(input word_t v);
    small_s0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t small_s1(input word_t v);
    small_s1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

// ----- sv/s256ps_cell.sv -----
// ---------------------------------------------------------------------------
// s256ps_cell
// One 32-bit word of the schedule window. Shifts a byte in from its right
// neighbor while a block is loaded, or takes the word two places to its
// right while word pairs are emitted.
// ---------------------------------------------------------------------------
module s256ps_cell (
  input  logic                   clk,
  input  s256ps_pkg::cell_mode_t mode,
  input  logic [7:0]             byte_in,
  input  s256ps_pkg::word_t      word_in,
  output s256ps_pkg::word_t      word_r
);
  import s256ps_pkg::*;

  word_t word_nxt;

  // next word by mode
  always_comb begin
    unique case (mode)
      CM_BYTE: word_nxt = {word_r[WordW-9:0], byte_in};
      CM_PAIR: word_nxt = word_in;
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

// ----- sv/s256ps_expand.sv -----
// ---------------------------------------------------------------------------
// s256ps_expand
// Message expansion for two schedule words at once. With the window holding
// W[t..t+15], it forms W[t+16] and W[t+17]; neither depends on the other.
// ---------------------------------------------------------------------------
module s256ps_expand (
  input  s256ps_pkg::word_t w0,
  input  s256ps_pkg::word_t w1,
  input  s256ps_pkg::word_t w2,
  input  s256ps_pkg::word_t w9,
  input  s256ps_pkg::word_t w10,
  input  s256ps_pkg::word_t w14,
  input  s256ps_pkg::word_t w15,
  output s256ps_pkg::word_t new_lo,
  output s256ps_pkg::word_t new_hi
);
  import s256ps_pkg::*;

  // four-operand sums, mod 2^32
  assign new_lo = small_s1(w14) + w9  + small_s0(w1) + w0;
  assign new_hi = small_s1(w15) + w10 + small_s0(w2) + w1;

endmodule

// ----- sv/sha256_pad_and_schedule.sv -----
// A block's first pair is shown the cycle after its 64th byte enters the chain.
// One byte per cycle is taken while idle; a full block then emits its 32 pairs.
// A message end pads to the block's last slot, and adds a block when the length overflows.
// Each padded block is followed by its emit run; out_stall holds the chain.
// The 16-cell window moves one byte or one word pair per cycle unless out_stall holds it.
// Reset clears state, byte slot and bit length; the word chain is not reset.
// ---------------------------------------------------------------------------
// sha256_pad_and_schedule
// Collects message bytes into 64-byte blocks in a chain of word cells, pads
// the message end with 0x80, zeros and the 64-bit bit length, and streams
// the 64 schedule words of each block as 32 pairs.
// ---------------------------------------------------------------------------
module sha256_pad_and_schedule (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_message_end,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_word_even,
  output logic [31:0] out_word_odd,
  output logic [4:0]  out_pair_index,
  output logic        out_final_block,
  output logic        out_last_of_run
);
  import s256ps_pkg::*;
  `include "assert_macros.svh"

  state_t      state_r, state_nxt;
  logic [5:0]  pos_r;         // next byte slot in the block
  logic [63:0] bitlen_r;      // message length in bits
  logic [4:0]  pair_r;        // pair being shown
  logic        final_r;       // block being shown is the last padded one
  logic        pad_act_r;     // message end seen, padding not yet done
  logic        pad_first_r;   // next pad byte is the 0x80 marker
  logic        len_ok_r;      // this padded block carries the length field

  cell_mode_t  mode;
  logic [7:0]  chain_byte;
  logic [7:0]  pad_byte;
  logic [7:0]  len_byte;
  logic        in_acc;
  logic        out_acc;
  logic        len_ok_eff;
  word_t       cw [NumCell];
  word_t       new_lo, new_hi;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // length byte for slot 56..63, big-endian
  assign len_byte   = 8'(bitlen_r >> {~pos_r[2:0], 3'b000});
  assign len_ok_eff = pad_first_r ? (pos_r < LEN_POS) : len_ok_r;

  always_comb begin
    priority if (pad_first_r)                  pad_byte = PAD_MARK;
    else if (len_ok_r && (pos_r >= LEN_POS))   pad_byte = len_byte;
    else                                       pad_byte = 8'h00;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_byte_valid && (pos_r == LAST_POS)) state_nxt = ST_EMIT;
          else if (in_message_end)                  state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (pos_r == LAST_POS) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall && (pair_r == LAST_PAIR)) begin
          state_nxt = (pad_act_r && !final_r) ? ST_PAD : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake and chain control
  always_comb begin
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    mode       = CM_HOLD;
    chain_byte = pad_byte;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        chain_byte = in_data_byte;
        if (in_valid && in_byte_valid) mode = CM_BYTE;
      end
      ST_PAD: begin
        mode = CM_BYTE;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) mode = CM_PAIR;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      bitlen_r    <= '0;
      pair_r      <= '0;
      final_r     <= 1'b0;
      pad_act_r   <= 1'b0;
      pad_first_r <= 1'b0;
      len_ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            final_r <= 1'b0;
            if (in_byte_valid) begin
              pos_r    <= pos_r + 6'd1;
              bitlen_r <= bitlen_r + BITS_PER_BYTE;
            end
            if (in_message_end) begin
              pad_act_r   <= 1'b1;
              pad_first_r <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          pos_r <= pos_r + 6'd1;
          if (pad_first_r) begin
            pad_first_r <= 1'b0;
            len_ok_r    <= pos_r < LEN_POS;
          end
          if (pos_r == LAST_POS) final_r <= len_ok_eff;
        end
        ST_EMIT: begin
          if (!out_stall) begin
            pair_r <= pair_r + 5'd1;
            if (pair_r == LAST_PAIR) begin
              if (final_r) begin
                pad_act_r <= 1'b0;
                len_ok_r  <= 1'b0;
                bitlen_r  <= '0;
              end else if (pad_act_r) begin
                // overflow block done, the next one holds the length
                len_ok_r <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // word chain: cell i reads bytes from i+1, words from i+2; past the end, chain_byte and new_*
  for (genvar i = 0; i < NumCell; i++) begin : g_cell
    logic [7:0] byte_in;
    word_t      word_in;
    if (i == NumCell - 1) begin : g_tail
      assign byte_in = chain_byte;
      assign word_in = new_hi;
    end else if (i == NumCell - 2) begin : g_pen
      assign byte_in = cw[i+1][WordW-1 -: 8];
      assign word_in = new_lo;
    end else begin : g_body
      assign byte_in = cw[i+1][WordW-1 -: 8];
      assign word_in = cw[i+2];
    end
    s256ps_cell u_cell (
      .clk     (clk),
      .mode    (mode),
      .byte_in (byte_in),
      .word_in (word_in),
      .word_r  (cw[i])
    );
  end

  s256ps_expand u_expand (
    .w0     (cw[0]),
    .w1     (cw[1]),
    .w2     (cw[2]),
    .w9     (cw[9]),
    .w10    (cw[10]),
    .w14    (cw[14]),
    .w15    (cw[15]),
    .new_lo (new_lo),
    .new_hi (new_hi)
  );

  // result transaction
  assign out_word_even   = cw[0];
  assign out_word_odd    = cw[1];
  assign out_pair_index  = pair_r;
  assign out_final_block = final_r;
  assign out_last_of_run = (pair_r == LAST_PAIR) && (final_r || !pad_act_r);

  // checks
  `S256_ASSERT_NOW(a_no_in_while_out, out_valid, in_stall, "input taken during emit")
  `S256_ASSERT_NOW(a_pair_only_in_emit, pair_r != 5'd0, state_r == ST_EMIT, "pair count off")
  `S256_ASSERT_NEXT(a_full_block_emits, in_acc && in_byte_valid && (pos_r == LAST_POS), state_r == ST_EMIT && pos_r == 6'd0, "full block not emitted")
  `S256_ASSERT_NEXT(a_final_clears, out_acc && final_r && (pair_r == LAST_PAIR), state_r == ST_IDLE && bitlen_r == 64'd0 && !pad_act_r, "message state not cleared")
  `S256_ASSERT_NOW(a_final_only_padding, out_valid && final_r, pad_act_r, "final block outside padding")

endmodule
